>>> src/assert_macros.svh
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LSPS_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("same-cycle check failed");
`define LSPS_ASSERT_NXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle check failed");
`else
`define LSPS_ASSERT_IMP(label, clk, rst, pre, post)
`define LSPS_ASSERT_NXT(label, clk, rst, pre, post)
`endif
`endif

>>> src/lsps_pkg.sv
// types, constants and codes of the line sensor pid steering block
package lsps_pkg;

   localparam int READING_BITS  = 10;
   localparam int INTEGRAL_BITS = 32;

   localparam int SENSOR_COUNT = 8;
   localparam int THR_BITS     = 10;
   localparam int GAIN_BITS    = 24;
   localparam int GAIN_FRAC    = 16;
   localparam int SPEED_BITS   = 16;
   localparam int ERR_BITS     = 16;
   localparam int ERR_FRAC     = 8;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 24;

   localparam int CMP_BITS  = (READING_BITS > THR_BITS) ? READING_BITS : THR_BITS;
   localparam int CNT_BITS  = $clog2(SENSOR_COUNT + 1);
   localparam int WSUM_BITS = 9;
   localparam int QUO_BITS  = WSUM_BITS + ERR_FRAC;
   localparam int DIV_CNT_BITS = $clog2(QUO_BITS + 1);
   localparam int DIFF_BITS = ERR_BITS + 1;
   localparam int LANE_BITS = (INTEGRAL_BITS > DIFF_BITS) ? INTEGRAL_BITS : DIFF_BITS;
   localparam int MUL_CNT_BITS = $clog2(GAIN_BITS + 1);
   localparam int PROD_BITS = LANE_BITS + 1 + GAIN_BITS - GAIN_FRAC;
   localparam int SUM_BITS  = PROD_BITS + 2;

   typedef logic [READING_BITS-1:0]        reading_type;
   typedef logic signed [ERR_BITS-1:0]     err_type;
   typedef logic signed [DIFF_BITS-1:0]    diff_type;
   typedef logic signed [INTEGRAL_BITS-1:0] integ_type;
   typedef logic signed [LANE_BITS-1:0]    lane_type;
   typedef logic signed [PROD_BITS-1:0]    prod_type;
   typedef logic signed [SUM_BITS-1:0]     sum_type;
   typedef logic signed [QUO_BITS:0]       quo_ext_type;

   typedef struct packed {
      logic [CNT_BITS-1:0]  count;
      logic [WSUM_BITS-1:0] wsum;
   } sense_type;

   localparam logic [6:0] SENSOR_WEIGHT [SENSOR_COUNT] =
      '{7'd10, 7'd20, 7'd30, 7'd40, 7'd50, 7'd60, 7'd70, 7'd80};

   localparam int      ERR_OFFSET = 45 * 256;
   localparam err_type ERR_ALL_ON = 16'sd25600;

   localparam integ_type INTEG_MAX = {1'b0, {(INTEGRAL_BITS-1){1'b1}}};
   localparam integ_type INTEG_MIN = {1'b1, {(INTEGRAL_BITS-1){1'b0}}};

   localparam logic [THR_BITS-1:0]   THR_RESET    = 10'd900;
   localparam logic [GAIN_BITS-1:0]  GP_RESET     = 24'd65536;
   localparam logic [GAIN_BITS-1:0]  GD_RESET     = 24'd655360;
   localparam logic [GAIN_BITS-1:0]  GI_RESET     = 24'd66;
   localparam logic [SPEED_BITS-1:0] LIMIT_RESET  = 16'd1792;
   localparam logic [SPEED_BITS-1:0] CRUISE_RESET = 16'd1280;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_THRESHOLD = 3'd0,
      CSR_GAIN_P    = 3'd1,
      CSR_GAIN_D    = 3'd2,
      CSR_GAIN_I    = 3'd3,
      CSR_LIMIT     = 3'd4,
      CSR_CRUISE    = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLASSIFY,
      ST_DIVIDE,
      ST_INTEG,
      ST_MULT,
      ST_SUM,
      ST_SPEED,
      ST_FINISH
   } state_type;

endpackage

>>> src/lsps_if.sv
// request, response and register write channel interfaces
interface lsps_req_if import lsps_pkg::*; ();
   logic        valid;
   logic        ready;
   reading_type right_far;
   reading_type right_mid;
   reading_type right_near;
   reading_type right_center;
   reading_type left_center;
   reading_type left_near;
   reading_type left_mid;
   reading_type left_far;

   modport source (output valid, right_far, right_mid, right_near, right_center,
                   left_center, left_near, left_mid, left_far, input ready);
   modport sink (input valid, right_far, right_mid, right_near, right_center,
                 left_center, left_near, left_mid, left_far, output ready);
endinterface

interface lsps_rsp_if import lsps_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [SPEED_BITS-1:0] left_cmd;
   logic [SPEED_BITS-1:0] right_cmd;
   err_type               line_error;
   logic                  line_lost;

   modport source (output valid, left_cmd, right_cmd, line_error, line_lost,
                   input ready);
   modport sink (input valid, left_cmd, right_cmd, line_error, line_lost,
                 output ready);
endinterface

interface lsps_csr_if import lsps_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_BITS-1:0]  index;
   logic [CSR_DATA_BITS-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> src/lsps_sense.sv
// sensor threshold compare with active count and weight sum
module lsps_sense import lsps_pkg::*; (
   input  reading_type         readings [SENSOR_COUNT],
   input  logic [THR_BITS-1:0] threshold,
   output sense_type           sense
);

   logic [CNT_BITS-1:0]  cnt;
   logic [WSUM_BITS-1:0] ws;

   always_comb begin
      cnt = '0;
      ws  = '0;
      for (int k = 0; k < SENSOR_COUNT; k++) begin
         if (CMP_BITS'(readings[k]) < CMP_BITS'(threshold)) begin
            ws  = ws + WSUM_BITS'(SENSOR_WEIGHT[k]);
            cnt = cnt + CNT_BITS'(1);
         end
      end
   end

   assign sense.count = cnt;
   assign sense.wsum  = ws;

endmodule

>>> src/lsps_div.sv
// restoring divider, one quotient bit per cycle
module lsps_div import lsps_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [QUO_BITS-1:0] dividend,
   input  logic [CNT_BITS-1:0] divisor,
   output logic                ready,
   output logic [QUO_BITS-1:0] quotient
);

   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [QUO_BITS-1:0]     q_ff, q_in;
   logic [CNT_BITS-1:0]     rem_ff, rem_in;
   logic [CNT_BITS-1:0]     dvs_ff;
   logic [CNT_BITS:0]       trial;
   logic [CNT_BITS:0]       diff;
   logic                    ge;

   always_comb begin
      trial  = {rem_ff, q_ff[QUO_BITS-1]};
      ge     = trial >= {1'b0, dvs_ff};
      diff   = trial - {1'b0, dvs_ff};
      cnt_in = cnt_ff;
      q_in   = q_ff;
      rem_in = rem_ff;
      if (start) begin
         cnt_in = DIV_CNT_BITS'(QUO_BITS);
         q_in   = dividend;
         rem_in = '0;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - DIV_CNT_BITS'(1);
         q_in   = {q_ff[QUO_BITS-2:0], ge};
         rem_in = ge ? diff[CNT_BITS-1:0] : trial[CNT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign ready    = (cnt_ff == '0);
   assign quotient = q_ff;

endmodule

>>> src/lsps_sermul.sv
// serial-parallel multiplier, one gain bit per cycle, result floored by the gain fraction
module lsps_sermul import lsps_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [GAIN_BITS-1:0] gain,
   input  lane_type             operand,
   output logic                 ready,
   output prod_type             product
);

   logic [MUL_CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic signed [LANE_BITS:0] hi_ff, hi_in;
   logic signed [LANE_BITS:0] x_ext;
   logic signed [LANE_BITS:0] part;
   logic [GAIN_BITS-1:0]     lo_ff, lo_in;
   logic [GAIN_BITS-1:0]     g_ff, g_in;
   lane_type                 x_ff;

   always_comb begin
      x_ext  = {x_ff[LANE_BITS-1], x_ff};
      part   = hi_ff + (g_ff[0] ? x_ext : '0);
      cnt_in = cnt_ff;
      hi_in  = hi_ff;
      lo_in  = lo_ff;
      g_in   = g_ff;
      if (start) begin
         cnt_in = MUL_CNT_BITS'(GAIN_BITS);
         hi_in  = '0;
         lo_in  = '0;
         g_in   = gain;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - MUL_CNT_BITS'(1);
         // arithmetic shift of the partial sum, low bit falls into the low word
         hi_in  = {part[LANE_BITS], part[LANE_BITS:1]};
         lo_in  = {part[0], lo_ff[GAIN_BITS-1:1]};
         g_in   = {1'b0, g_ff[GAIN_BITS-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff <= hi_in;
      lo_ff <= lo_in;
      g_ff  <= g_in;
      if (start) begin
         x_ff <= operand;
      end
   end

   assign ready   = (cnt_ff == '0);
   assign product = {hi_ff, lo_ff[GAIN_BITS-1:GAIN_FRAC]};

endmodule

>>> src/line_sensor_pid_steering.sv
// top level of the line sensor pid steering block
//
// Takes one beat of eight line-sensor readings and returns one beat with the
// left and right wheel speeds (Q8.8, clamped to 0..speed_limit), the signed
// Q8.8 line error and a line-lost flag. Items are handled one at a time:
// a normal item goes through the classify step, the 17-bit restoring
// divider for the weighted mean, the integrate step, the three
// serial-parallel gain multipliers running side by side over the 24 gain
// bits, and the sum, speed and output steps. With every sensor on the
// divider is skipped; with no sensor on the held speeds come back and no
// loop state changes. A finished result waits in the output register
// while the next item is accepted. Registers are written through the
// csr channel, always ready; the user writes them only while the block
// is idle, as the block itself does not enforce it. Indexes beyond the
// list are ignored.

`include "assert_macros.svh"

module line_sensor_pid_steering import lsps_pkg::*; (
   input logic         clock,
   input logic         reset,
   lsps_req_if.sink    req_bus,
   lsps_rsp_if.source  rsp_bus,
   lsps_csr_if.sink    csr_bus
);

   // configuration registers
   logic [THR_BITS-1:0]   thr_ff;
   logic [GAIN_BITS-1:0]  gp_ff;
   logic [GAIN_BITS-1:0]  gd_ff;
   logic [GAIN_BITS-1:0]  gi_ff;
   logic [SPEED_BITS-1:0] limit_ff;
   logic [SPEED_BITS-1:0] cruise_ff;

   // controller state
   state_type state_ff, state_in;

   // persistent loop state
   err_type               last_err_ff;
   integ_type             integ_ff;
   logic [SPEED_BITS-1:0] held_left_ff;
   logic [SPEED_BITS-1:0] held_right_ff;

   // per-item working registers
   sense_type             sense_ff;
   err_type               err_ff;
   sum_type               sum_ff;
   logic [SPEED_BITS-1:0] res_left_ff;
   logic [SPEED_BITS-1:0] res_right_ff;
   err_type               res_err_ff;
   logic                  res_lost_ff;

   // output register
   logic                  rsp_valid_ff;
   logic [SPEED_BITS-1:0] rsp_left_ff;
   logic [SPEED_BITS-1:0] rsp_right_ff;
   err_type               rsp_err_ff;
   logic                  rsp_lost_ff;

   // controls
   logic req_take;
   logic out_free;
   logic start_div;
   logic load_err_div;
   logic load_err_full;
   logic load_lost;
   logic start_mul;
   logic load_sum;
   logic load_speed;
   logic push_out;

   // datapath nets
   reading_type         readings [SENSOR_COUNT];
   sense_type           sense_c;
   logic                div_ready;
   logic [QUO_BITS-1:0] quotient;
   quo_ext_type         err_div;
   diff_type            diff_c;
   logic signed [INTEGRAL_BITS:0] acc_sum;
   integ_type           acc_sat;
   logic                rdy_p, rdy_d, rdy_i;
   prod_type            prod_p, prod_d, prod_i;
   sum_type             pid_c;
   sum_type             cruise_ext;
   sum_type             v_left, v_right;
   logic [SPEED_BITS-1:0] spd_left_c, spd_right_c;

   function automatic logic [SPEED_BITS-1:0] clamp_speed(input sum_type v,
                                                         input logic [SPEED_BITS-1:0] lim);
      sum_type lim_ext;
      lim_ext = sum_type'({1'b0, lim});
      if (v[SUM_BITS-1]) begin
         return '0;
      end else if (v > lim_ext) begin
         return lim;
      end
      return v[SPEED_BITS-1:0];
   endfunction

   // readings in weight order, right far first
   assign readings[0] = req_bus.right_far;
   assign readings[1] = req_bus.right_mid;
   assign readings[2] = req_bus.right_near;
   assign readings[3] = req_bus.right_center;
   assign readings[4] = req_bus.left_center;
   assign readings[5] = req_bus.left_near;
   assign readings[6] = req_bus.left_mid;
   assign readings[7] = req_bus.left_far;

   lsps_sense u_sense (
      .readings  (readings),
      .threshold (thr_ff),
      .sense     (sense_c)
   );

   // weighted mean: (wsum * 256) / count
   lsps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_div),
      .dividend ({sense_ff.wsum, {ERR_FRAC{1'b0}}}),
      .divisor  (sense_ff.count),
      .ready    (div_ready),
      .quotient (quotient)
   );

   assign err_div = $signed({1'b0, quotient}) - quo_ext_type'(ERR_OFFSET);

   // derivative and saturating integral, taken in the integrate step
   always_comb begin
      diff_c  = diff_type'(err_ff) - diff_type'(last_err_ff);
      acc_sum = {{(INTEGRAL_BITS-ERR_BITS+1){err_ff[ERR_BITS-1]}}, err_ff}
              + {integ_ff[INTEGRAL_BITS-1], integ_ff};
      if (acc_sum[INTEGRAL_BITS] != acc_sum[INTEGRAL_BITS-1]) begin
         acc_sat = acc_sum[INTEGRAL_BITS] ? INTEG_MIN : INTEG_MAX;
      end else begin
         acc_sat = acc_sum[INTEGRAL_BITS-1:0];
      end
   end

   // three gain lanes, each floored to Q8.8 on its own
   lsps_sermul u_mul_p (
      .clock   (clock),
      .reset   (reset),
      .start   (start_mul),
      .gain    (gp_ff),
      .operand (lane_type'(err_ff)),
      .ready   (rdy_p),
      .product (prod_p)
   );

   lsps_sermul u_mul_d (
      .clock   (clock),
      .reset   (reset),
      .start   (start_mul),
      .gain    (gd_ff),
      .operand (lane_type'(diff_c)),
      .ready   (rdy_d),
      .product (prod_d)
   );

   lsps_sermul u_mul_i (
      .clock   (clock),
      .reset   (reset),
      .start   (start_mul),
      .gain    (gi_ff),
      .operand (lane_type'(acc_sat)),
      .ready   (rdy_i),
      .product (prod_i)
   );

   // halved pid term and wheel speeds
   always_comb begin
      pid_c       = sum_ff >>> 1;
      cruise_ext  = sum_type'({1'b0, cruise_ff});
      v_left      = cruise_ext - pid_c;
      v_right     = cruise_ext + pid_c;
      spd_left_c  = clamp_speed(v_left, limit_ff);
      spd_right_c = clamp_speed(v_right, limit_ff);
   end

   assign req_take = req_bus.valid && req_bus.ready;
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            if (sense_ff.count == '0) begin
               state_in = ST_FINISH;
            end else if (sense_ff.count == CNT_BITS'(SENSOR_COUNT)) begin
               state_in = ST_INTEG;
            end else begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_ready) begin
               state_in = ST_INTEG;
            end
         end
         ST_INTEG: state_in = ST_MULT;
         ST_MULT: begin
            if (rdy_p && rdy_d && rdy_i) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM:   state_in = ST_SPEED;
         ST_SPEED: state_in = ST_FINISH;
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // controls per state
   always_comb begin
      req_bus.ready = 1'b0;
      start_div     = 1'b0;
      load_err_div  = 1'b0;
      load_err_full = 1'b0;
      load_lost     = 1'b0;
      start_mul     = 1'b0;
      load_sum      = 1'b0;
      load_speed    = 1'b0;
      push_out      = 1'b0;
      case (state_ff)
         ST_IDLE: req_bus.ready = 1'b1;
         ST_CLASSIFY: begin
            if (sense_ff.count == '0) begin
               load_lost = 1'b1;
            end else if (sense_ff.count == CNT_BITS'(SENSOR_COUNT)) begin
               load_err_full = 1'b1;
            end else begin
               start_div = 1'b1;
            end
         end
         ST_DIVIDE: load_err_div = div_ready;
         ST_INTEG:  start_mul    = 1'b1;
         ST_MULT:   ;
         ST_SUM:    load_sum     = 1'b1;
         ST_SPEED:  load_speed   = 1'b1;
         ST_FINISH: push_out     = out_free;
         default:   ;
      endcase
   end

   assign csr_bus.ready = 1'b1;

   // control registers and loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         thr_ff        <= THR_RESET;
         gp_ff         <= GP_RESET;
         gd_ff         <= GD_RESET;
         gi_ff         <= GI_RESET;
         limit_ff      <= LIMIT_RESET;
         cruise_ff     <= CRUISE_RESET;
         last_err_ff   <= '0;
         integ_ff      <= '0;
         held_left_ff  <= '0;
         held_right_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_THRESHOLD: thr_ff    <= csr_bus.data[THR_BITS-1:0];
               CSR_GAIN_P:    gp_ff     <= csr_bus.data[GAIN_BITS-1:0];
               CSR_GAIN_D:    gd_ff     <= csr_bus.data[GAIN_BITS-1:0];
               CSR_GAIN_I:    gi_ff     <= csr_bus.data[GAIN_BITS-1:0];
               CSR_LIMIT:     limit_ff  <= csr_bus.data[SPEED_BITS-1:0];
               CSR_CRUISE:    cruise_ff <= csr_bus.data[SPEED_BITS-1:0];
               default:       ;
            endcase
         end
         // loop state moves only when the line is seen
         if (start_mul) begin
            last_err_ff <= err_ff;
            integ_ff    <= acc_sat;
         end
         if (load_speed) begin
            held_left_ff  <= spd_left_c;
            held_right_ff <= spd_right_c;
         end
         if (push_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         sense_ff <= sense_c;
      end
      if (load_err_full) begin
         err_ff <= ERR_ALL_ON;
      end else if (load_err_div) begin
         err_ff <= err_div[ERR_BITS-1:0];
      end
      if (load_sum) begin
         sum_ff <= sum_type'(prod_p) + sum_type'(prod_d) + sum_type'(prod_i);
      end
      if (load_lost) begin
         res_left_ff  <= held_left_ff;
         res_right_ff <= held_right_ff;
         res_err_ff   <= '0;
         res_lost_ff  <= 1'b1;
      end else if (load_speed) begin
         res_left_ff  <= spd_left_c;
         res_right_ff <= spd_right_c;
         res_err_ff   <= err_ff;
         res_lost_ff  <= 1'b0;
      end
      if (push_out) begin
         rsp_left_ff  <= res_left_ff;
         rsp_right_ff <= res_right_ff;
         rsp_err_ff   <= res_err_ff;
         rsp_lost_ff  <= res_lost_ff;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.left_cmd   = rsp_left_ff;
   assign rsp_bus.right_cmd  = rsp_right_ff;
   assign rsp_bus.line_error = rsp_err_ff;
   assign rsp_bus.line_lost  = rsp_lost_ff;

   // a lost-line beat always carries a zero error
   `LSPS_ASSERT_IMP(a_lost_zero_error, clock, reset, rsp_valid_ff && rsp_lost_ff, rsp_err_ff == '0)
   // the three gain lanes run in lockstep
   `LSPS_ASSERT_IMP(a_lanes_lockstep, clock, reset, state_ff == ST_MULT, rdy_p == rdy_d && rdy_d == rdy_i)
   // an accepted beat is classified in the next cycle
   `LSPS_ASSERT_NXT(a_accept_classify, clock, reset, req_take, state_ff == ST_CLASSIFY)

endmodule
